// ===== hw/rtl/drp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the rate pacer.
package drp_pkg;

    localparam int COUNT_BITS   = 40;
    localparam int TIME_BITS    = 62;
    localparam int RATE_BITS    = 32;
    localparam int USEC_BITS    = 20;
    localparam int PROD_BITS    = COUNT_BITS + USEC_BITS;
    localparam int WIDE_BITS    = (PROD_BITS > TIME_BITS) ? PROD_BITS + 1 : TIME_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);
    localparam int IDLE_BITS    = 7;
    localparam int SLEEP_BITS   = 17;
    localparam int CFG_IDX_BITS = 2;
    localparam int RECIP_BITS   = 18;
    localparam int MS_SHIFT     = 27;
    localparam int HINT_PROD_BITS = SLEEP_BITS + RECIP_BITS;

    localparam logic [USEC_BITS-1:0]  USEC_PER_SEC = USEC_BITS'(1000000);
    localparam logic [TIME_BITS-1:0]  MS_US        = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0]  SLEEP_CAP_US = TIME_BITS'(100 * 1000);
    localparam logic [IDLE_BITS-1:0]  IDLE_CAP_MS  = IDLE_BITS'(100);
    localparam logic [RECIP_BITS-1:0] MS_RECIP     = RECIP_BITS'(134218);
    localparam logic [TIME_BITS-1:0]  TIME_MAX     = {TIME_BITS{1'b1}};

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_OPS_RATE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_TIME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_FLAG  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic tick;
        logic cap_poll;
        logic mul;
        logic div;
        logic fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// ===== hw/rtl/drp_ctrl.sv =====
// Controller state machine that sequences capture, multiply, divide, finish and result load.
module drp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            op,
    output logic            out_valid,
    input  logic            out_ready,
    input  drp_pkg::status_t status,
    output drp_pkg::cmd_t   cmd
);
    import drp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_POLL))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.tick     = accept && (op == OP_TICK);
                cmd.cap_poll = accept && (op == OP_POLL);
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
            end
            ST_OUT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/drp_datapath.sv =====
// Datapath with configuration registers, event counter, deadline divider and result registers.
module drp_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  drp_pkg::cmd_t                      cmd,
    output drp_pkg::status_t                   status,
    input  logic [drp_pkg::TIME_BITS-1:0]      now_us,
    input  logic                               cfg_write,
    input  logic [drp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [drp_pkg::TIME_BITS-1:0]      cfg_data,
    output logic                               due,
    output logic [drp_pkg::TIME_BITS-1:0]      amount_us,
    output logic [drp_pkg::IDLE_BITS-1:0]      idle_wait_ms,
    output logic [drp_pkg::SLEEP_BITS-1:0]     sleep_hint_us
);
    import drp_pkg::*;

    logic [RATE_BITS-1:0]    ops_rate_reg;
    logic [TIME_BITS-1:0]    start_time_reg;
    logic                    idle_flag_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [PROD_BITS-1:0]    quot_reg;
    logic [RATE_BITS-1:0]    rem_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [TIME_BITS-1:0]    diff_reg;
    logic                    ge_reg;
    logic                    fin_due_reg;
    logic [TIME_BITS-1:0]    fin_amount_reg;
    logic                    due_reg;
    logic [TIME_BITS-1:0]    amount_reg;
    logic [IDLE_BITS-1:0]    idle_reg;
    logic [SLEEP_BITS-1:0]   sleep_reg;

    logic [RATE_BITS:0]      trial;
    logic                    qbit;
    logic [RATE_BITS:0]      trial_sub;
    logic [WIDE_BITS-1:0]    q_w;
    logic [WIDE_BITS-1:0]    d_w;
    logic [WIDE_BITS-1:0]    rem_w;
    logic                    fin_due_next;
    logic [TIME_BITS-1:0]    fin_amount_next;
    logic [HINT_PROD_BITS-1:0] hint_prod;
    logic                    below_ms;
    logic                    big;
    logic [IDLE_BITS-1:0]    idle_next;
    logic [SLEEP_BITS-1:0]   sleep_next;

    assign status.div_last = (div_cnt_reg == '0);

    // Restoring division step: one quotient bit per cycle.
    assign trial     = {rem_reg, quot_reg[PROD_BITS-1]};
    assign qbit      = (trial >= {1'b0, ops_rate_reg});
    assign trial_sub = trial - {1'b0, ops_rate_reg};

    always_comb
    begin
        q_w             = WIDE_BITS'(quot_reg);
        d_w             = WIDE_BITS'(diff_reg);
        rem_w           = '0;
        fin_due_next    = 1'b0;
        fin_amount_next = '0;
        if (ops_rate_reg == '0)
        begin
            fin_due_next = 1'b1;
        end
        else if (ge_reg && (d_w >= q_w))
        begin
            fin_due_next    = 1'b1;
            fin_amount_next = TIME_BITS'(d_w - q_w);
        end
        else
        begin
            if (ge_reg)
            begin
                rem_w = q_w - d_w;
            end
            else
            begin
                rem_w = q_w + d_w;
            end
            if (rem_w > WIDE_BITS'(TIME_MAX))
            begin
                fin_amount_next = TIME_MAX;
            end
            else
            begin
                fin_amount_next = TIME_BITS'(rem_w);
            end
        end
    end

    assign below_ms  = (fin_amount_reg < MS_US);
    assign big       = (fin_amount_reg >= SLEEP_CAP_US);
    assign hint_prod = HINT_PROD_BITS'(fin_amount_reg[SLEEP_BITS-1:0])
                       * HINT_PROD_BITS'(MS_RECIP);

    always_comb
    begin
        idle_next  = '0;
        sleep_next = '0;
        if (!fin_due_reg && !below_ms)
        begin
            if (idle_flag_reg)
            begin
                idle_next = big ? IDLE_CAP_MS : hint_prod[MS_SHIFT +: IDLE_BITS];
            end
            else
            begin
                sleep_next = big ? SLEEP_CAP_US[SLEEP_BITS-1:0]
                                 : fin_amount_reg[SLEEP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_rate_reg   <= '0;
            start_time_reg <= '0;
            idle_flag_reg  <= 1'b0;
            count_reg      <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_OPS_RATE:   ops_rate_reg   <= cfg_data[RATE_BITS-1:0];
                    REG_START_TIME: start_time_reg <= cfg_data;
                    REG_IDLE_FLAG:  idle_flag_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (cmd.tick && (count_reg != {COUNT_BITS{1'b1}}))
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.mul)
            begin
                div_cnt_reg <= DIV_CNT_BITS'(PROD_BITS - 1);
            end
            else if (cmd.div && !status.div_last)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_poll)
        begin
            now_reg <= now_us;
        end
        if (cmd.mul)
        begin
            quot_reg <= PROD_BITS'(count_reg) * PROD_BITS'(USEC_PER_SEC);
            rem_reg  <= '0;
            ge_reg   <= (now_reg >= start_time_reg);
            diff_reg <= (now_reg >= start_time_reg) ? (now_reg - start_time_reg)
                                                    : (start_time_reg - now_reg);
        end
        if (cmd.div)
        begin
            quot_reg <= {quot_reg[PROD_BITS-2:0], qbit};
            rem_reg  <= qbit ? trial_sub[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
        end
        if (cmd.fin)
        begin
            fin_due_reg    <= fin_due_next;
            fin_amount_reg <= fin_amount_next;
        end
        if (cmd.load_out)
        begin
            due_reg    <= fin_due_reg;
            amount_reg <= fin_amount_reg;
            idle_reg   <= idle_next;
            sleep_reg  <= sleep_next;
        end
    end

    assign due           = due_reg;
    assign amount_us     = amount_reg;
    assign idle_wait_ms  = idle_reg;
    assign sleep_hint_us = sleep_reg;

endmodule

// ===== hw/rtl/drift_free_rate_pacer.sv =====
// Top level of the drift-free rate pacer: controller, datapath and checks.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   op, now_us
//  out      out_valid / out_ready due, amount_us, idle_wait_ms, sleep_hint_us
//  cfg      cfg_write             cfg_index, cfg_data
//
// A tick advances the event count, which saturates, and gives no result.
// A poll passes through the multiply, divide and finish states before its result is loaded,
// and the restoring divider forms one quotient bit per cycle.
// Reset clears the configuration registers, the event count and all control state.
// A result waits in the output register; the next item can be taken meanwhile, and a
// poll that finishes while that result is still held stalls until it is taken.
module drift_free_rate_pacer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [drp_pkg::TIME_BITS-1:0]     now_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              due,
    output logic [drp_pkg::TIME_BITS-1:0]     amount_us,
    output logic [drp_pkg::IDLE_BITS-1:0]     idle_wait_ms,
    output logic [drp_pkg::SLEEP_BITS-1:0]    sleep_hint_us,
    input  logic                              cfg_write,
    input  logic [drp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [drp_pkg::TIME_BITS-1:0]     cfg_data
);
    import drp_pkg::*;

    cmd_t    cmd;
    status_t status;

    drp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    drp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .now_us        (now_us),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .due           (due),
        .amount_us     (amount_us),
        .idle_wait_ms  (idle_wait_ms),
        .sleep_hint_us (sleep_hint_us)
    );

    // A tick transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_TICK)) |=> !$rose(out_valid))
        else $error("result appeared after a tick");

    // A due result carries no wait hint.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && due) |-> ((idle_wait_ms == '0) && (sleep_hint_us == '0)))
        else $error("hint given on a due result");

    // A result that is not due always has time remaining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !due) |-> (amount_us != '0))
        else $error("zero remaining time on a result that is not due");

    // The two hints are never both set, and the idle hint respects its cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((idle_wait_ms == '0) || (sleep_hint_us == '0))
                       && (idle_wait_ms <= IDLE_CAP_MS)))
        else $error("wait hints out of range");

endmodule
